>>> rtl/gspi_pkg.sv
// Package with shared types, constants and saturation helpers of the gain-scheduled PI controller.
package gspi_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int WEIGHT_W  = 32;
    localparam int STEP_W    = 16;
    localparam int RATE_W    = 16;
    localparam int MUL_W     = 33;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int ACC_W     = 64;

    localparam logic [CFG_IDX_W-1:0] REG_P_CONST = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_P_LIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_P_QUAD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_I_CONST = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_I_LIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_I_QUAD  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STEP    = 3'd6;

    localparam logic signed [WEIGHT_W-1:0] P_CONST_RST = 32'sd0;
    localparam logic signed [WEIGHT_W-1:0] P_LIN_RST   = 32'sd0;
    localparam logic signed [WEIGHT_W-1:0] P_QUAD_RST  = 32'sd655;
    localparam logic signed [WEIGHT_W-1:0] I_CONST_RST = 32'sd0;
    localparam logic signed [WEIGHT_W-1:0] I_LIN_RST   = 32'sd0;
    localparam logic signed [WEIGHT_W-1:0] I_QUAD_RST  = 32'sd0;
    localparam logic [STEP_W-1:0]          STEP_RST    = 16'd655;

    typedef struct packed {
        logic signed [WEIGHT_W-1:0] p_const;
        logic signed [WEIGHT_W-1:0] p_lin;
        logic signed [WEIGHT_W-1:0] p_quad;
        logic signed [WEIGHT_W-1:0] i_const;
        logic signed [WEIGHT_W-1:0] i_lin;
        logic signed [WEIGHT_W-1:0] i_quad;
        logic [STEP_W-1:0]          step;
    } weights_t;

    // True when the value is representable in 32 signed bits.
    function automatic logic fits32(input logic signed [ACC_W-1:0] x);
        fits32 = (x[ACC_W-1:31] == '0) || (x[ACC_W-1:31] == '1);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
        if (fits32(x))
        begin
            sat32 = x[31:0];
        end
        else
        begin
            sat32 = x[ACC_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
    endfunction

    function automatic logic fits16(input logic signed [ACC_W-1:0] x);
        fits16 = (x[ACC_W-1:15] == '0) || (x[ACC_W-1:15] == '1);
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] x);
        if (fits16(x))
        begin
            sat16 = x[15:0];
        end
        else
        begin
            sat16 = x[ACC_W-1] ? 16'sh8000 : 16'sh7fff;
        end
    endfunction

endpackage

>>> rtl/gspi_if.sv
// Channel interfaces for the samples, the results and the register writes.
interface gspi_in_if;
    logic        valid;
    logic        ready;
    logic signed [gspi_pkg::RATE_W-1:0] target_rate;
    logic signed [gspi_pkg::RATE_W-1:0] measured_rate;
    logic signed [gspi_pkg::RATE_W-1:0] vehicle_speed;

    modport source (output valid, target_rate, measured_rate, vehicle_speed, input ready);
    modport sink   (input valid, target_rate, measured_rate, vehicle_speed, output ready);
endinterface

interface gspi_out_if;
    logic        valid;
    logic        ready;
    logic signed [gspi_pkg::RATE_W-1:0] steer_command;
    logic        saturated;

    modport source (output valid, steer_command, saturated, input ready);
    modport sink   (input valid, steer_command, saturated, output ready);
endinterface

interface gspi_cfg_if;
    logic        valid;
    logic        ready;
    logic [gspi_pkg::CFG_IDX_W-1:0] index;
    logic [gspi_pkg::WEIGHT_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/gspi_regs.sv
// Configuration register file holding the gain schedule weights and the step time.
module gspi_regs
(
    input  logic               clk,
    input  logic               rst_n,
    gspi_cfg_if.sink           cfg,
    output gspi_pkg::weights_t weights
);

    gspi_pkg::weights_t w_reg;

    assign cfg.ready = 1'b1;
    assign weights   = w_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg.p_const <= gspi_pkg::P_CONST_RST;
            w_reg.p_lin   <= gspi_pkg::P_LIN_RST;
            w_reg.p_quad  <= gspi_pkg::P_QUAD_RST;
            w_reg.i_const <= gspi_pkg::I_CONST_RST;
            w_reg.i_lin   <= gspi_pkg::I_LIN_RST;
            w_reg.i_quad  <= gspi_pkg::I_QUAD_RST;
            w_reg.step    <= gspi_pkg::STEP_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                gspi_pkg::REG_P_CONST: w_reg.p_const <= cfg.data;
                gspi_pkg::REG_P_LIN:   w_reg.p_lin   <= cfg.data;
                gspi_pkg::REG_P_QUAD:  w_reg.p_quad  <= cfg.data;
                gspi_pkg::REG_I_CONST: w_reg.i_const <= cfg.data;
                gspi_pkg::REG_I_LIN:   w_reg.i_lin   <= cfg.data;
                gspi_pkg::REG_I_QUAD:  w_reg.i_quad  <= cfg.data;
                gspi_pkg::REG_STEP:    w_reg.step    <= cfg.data[gspi_pkg::STEP_W-1:0];
                default:               w_reg         <= w_reg;
            endcase
        end
    end

endmodule

>>> rtl/gspi_mul.sv
// Shared signed multiplier with a registered product.
module gspi_mul
(
    input  logic                                clk,
    input  logic signed [gspi_pkg::MUL_W-1:0]   op_a,
    input  logic signed [gspi_pkg::MUL_W-1:0]   op_b,
    output logic signed [gspi_pkg::PROD_W-1:0]  prod_reg
);

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

endmodule

>>> rtl/gain_scheduled_pi_controller.sv
// Top level of the gain-scheduled PI controller: sequencer, accumulator and result register.
//
// Each sample transaction carries a yaw-rate setpoint, a measured yaw rate and the vehicle
// speed. The block schedules kp and ki as quadratics in speed from the configured Q16.16
// weights, integrates the error times step_time into a saturating Q15.16 integral and
// returns one result transaction with kp*error + ki*integral as a saturated Q3.12 steering
// command, plus a flag that is set when the integral or the command was clipped. All
// products go through one registered 33 by 33 bit multiplier that a small sequencer feeds
// one product per cycle, and one 64 bit adder folds them into an accumulator. After a
// sample is accepted the sequencer runs from ST_VV through ST_DONE, and the result becomes
// valid as it leaves ST_DONE; the sample channel is not ready during that time and is ready
// again from the cycle in which the result appears. A finished result sits in its own
// register until taken, so the next sample may already be accepted while it waits; if that
// register is still full when the following update finishes, the sequencer holds its
// result and the sample channel stays not ready until the waiting result is taken.
// Register writes are accepted in every cycle; they belong in the gaps where no sample is
// in flight and take effect from the next sample.
module gain_scheduled_pi_controller
(
    input  logic        clk,
    input  logic        rst_n,
    gspi_in_if.sink     sample,
    gspi_out_if.source  result,
    gspi_cfg_if.sink    cfg
);

    localparam int MW = gspi_pkg::MUL_W;
    localparam int AW = gspi_pkg::ACC_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_VV,
        ST_PLIN,
        ST_PQUAD,
        ST_ILIN,
        ST_IQUAD,
        ST_INTEG,
        ST_KPE,
        ST_KIE,
        ST_SUM,
        ST_DONE
    } state_t;

    gspi_pkg::weights_t weights;

    state_t state_reg, state_next;

    // Sample operands held for the whole update.
    logic signed [15:0] speed_reg, speed_next;
    logic signed [16:0] err_reg, err_next;
    logic signed [31:0] vv_reg, vv_next;
    logic signed [31:0] kp_reg, kp_next;
    logic signed [31:0] ki_reg, ki_next;
    logic signed [AW-1:0] acc_reg, acc_next;
    logic sat_reg, sat_next;

    // Controller state kept across samples.
    logic signed [31:0] integral_reg, integral_next;

    // Result register.
    logic               out_valid_reg, out_valid_next;
    logic signed [15:0] steer_reg, steer_next;
    logic               out_sat_reg, out_sat_next;

    logic signed [MW-1:0] op_a, op_b;
    logic signed [gspi_pkg::PROD_W-1:0] prod_reg;
    logic signed [AW-1:0] prod64;
    logic signed [AW-1:0] add_a, add_b, add_sum;
    logic signed [AW-1:0] acc_scaled;

    gspi_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .weights (weights)
    );

    gspi_mul u_mul
    (
        .clk      (clk),
        .op_a     (op_a),
        .op_b     (op_b),
        .prod_reg (prod_reg)
    );

    // All products stay well inside 64 bits, so the top bits of the multiplier are dropped.
    assign prod64     = prod_reg[AW-1:0];
    assign add_sum    = add_a + add_b;
    assign acc_scaled = acc_reg >>> 20;

    assign sample.ready         = (state_reg == ST_IDLE);
    assign result.valid         = out_valid_reg;
    assign result.steer_command = steer_reg;
    assign result.saturated     = out_sat_reg;

    // Multiplier operand selection; the product is registered before the adder and the vv register use it.
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (state_reg)
            ST_VV:
            begin
                op_a = MW'(speed_reg);
                op_b = MW'(speed_reg);
            end
            ST_PLIN:
            begin
                op_a = MW'(weights.p_lin);
                op_b = MW'(speed_reg);
            end
            ST_PQUAD:
            begin
                op_a = MW'(weights.p_quad);
                op_b = MW'(vv_reg);
            end
            ST_ILIN:
            begin
                op_a = MW'(weights.i_lin);
                op_b = MW'(speed_reg);
            end
            ST_IQUAD:
            begin
                op_a = MW'(weights.i_quad);
                op_b = MW'(vv_reg);
            end
            ST_INTEG:
            begin
                op_a = MW'(err_reg);
                op_b = $signed({{(MW-gspi_pkg::STEP_W){1'b0}}, weights.step});
            end
            ST_KPE:
            begin
                op_a = MW'(kp_reg);
                op_b = MW'(err_reg);
            end
            ST_KIE:
            begin
                op_a = MW'(ki_reg);
                op_b = MW'(integral_reg);
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // Adder operand selection. Right shifts are arithmetic, so they round toward minus
    // infinity as the fixed-point format requires.
    always_comb
    begin
        add_a = acc_reg;
        add_b = '0;
        case (state_reg)
            ST_PLIN:
            begin
                add_a = AW'(weights.p_const);
            end
            ST_PQUAD:
            begin
                add_b = prod64 >>> 8;
            end
            ST_ILIN:
            begin
                add_b = prod64 >>> 16;
            end
            ST_IQUAD:
            begin
                add_a = AW'(weights.i_const);
                add_b = prod64 >>> 8;
            end
            ST_INTEG:
            begin
                add_b = prod64 >>> 16;
            end
            ST_KPE:
            begin
                add_a = AW'(integral_reg);
                add_b = prod64 >>> 12;
            end
            ST_KIE:
            begin
                add_a = '0;
                add_b = prod64 <<< 4;
            end
            ST_SUM:
            begin
                add_b = prod64;
            end
            default:
            begin
                add_a = acc_reg;
                add_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        speed_next     = speed_reg;
        err_next       = err_reg;
        vv_next        = vv_reg;
        kp_next        = kp_reg;
        ki_next        = ki_reg;
        acc_next       = acc_reg;
        sat_next       = sat_reg;
        integral_next  = integral_reg;
        out_valid_next = out_valid_reg;
        steer_next     = steer_reg;
        out_sat_next   = out_sat_reg;

        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (sample.valid)
                begin
                    speed_next = sample.vehicle_speed;
                    err_next   = 17'(sample.target_rate) - 17'(sample.measured_rate);
                    sat_next   = 1'b0;
                    state_next = ST_VV;
                end
            end
            ST_VV:
            begin
                state_next = ST_PLIN;
            end
            ST_PLIN:
            begin
                vv_next    = prod64[31:0];
                acc_next   = add_sum;
                state_next = ST_PQUAD;
            end
            ST_PQUAD:
            begin
                acc_next   = add_sum;
                state_next = ST_ILIN;
            end
            ST_ILIN:
            begin
                acc_next   = add_sum;
                state_next = ST_IQUAD;
            end
            ST_IQUAD:
            begin
                // A clipped gain does not count as saturation.
                kp_next    = gspi_pkg::sat32(acc_reg);
                acc_next   = add_sum;
                state_next = ST_INTEG;
            end
            ST_INTEG:
            begin
                acc_next   = add_sum;
                state_next = ST_KPE;
            end
            ST_KPE:
            begin
                ki_next       = gspi_pkg::sat32(acc_reg);
                integral_next = gspi_pkg::sat32(add_sum);
                sat_next      = !gspi_pkg::fits32(add_sum);
                state_next    = ST_KIE;
            end
            ST_KIE:
            begin
                acc_next   = add_sum;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                acc_next   = add_sum;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // Wait here until the result register is free.
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    steer_next     = gspi_pkg::sat16(acc_scaled);
                    out_sat_next   = sat_reg || !gspi_pkg::fits16(acc_scaled);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            integral_reg  <= '0;
            out_valid_reg <= 1'b0;
            steer_reg     <= '0;
            out_sat_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            integral_reg  <= integral_next;
            out_valid_reg <= out_valid_next;
            steer_reg     <= steer_next;
            out_sat_reg   <= out_sat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        speed_reg   <= speed_next;
        err_reg     <= err_next;
        vv_reg      <= vv_next;
        kp_reg      <= kp_next;
        ki_reg      <= ki_next;
        acc_reg     <= acc_next;
        sat_reg     <= sat_next;
    end

endmodule

>>> rtl/gspi_checker.sv
// Port-level assertion checker for the gain-scheduled PI controller and its bind statement.
module gspi_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] steer_command,
    input logic        saturated,
    input logic        cfg_ready
);

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(steer_command) && $stable(saturated)))
        else $error("result changed while stalled");

    // The block works on one sample at a time.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("sample accepted while busy");

    // No result can appear in the cycle right after a sample is taken.
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !$rose(out_valid))
        else $error("result appeared too early");

    // A new result is only produced at the end of an update.
    a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without an update");

    // Register writes are never stalled.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("configuration port stalled");

endmodule

bind gain_scheduled_pi_controller gspi_checker u_gspi_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (sample.valid),
    .in_ready      (sample.ready),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .steer_command (result.steer_command),
    .saturated     (result.saturated),
    .cfg_ready     (cfg.ready)
);
